// ===== sv/sat_pkg.sv =====
package sat_pkg;

    localparam int MAX_ROW_LENGTH_DEF = 1024;
    localparam int SUM_WIDTH_DEF      = 48;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int LEN_W    = 11;
    localparam int IDX_W    = 10;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W + 1;
    localparam int ROW_LIMIT = 1024;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_WEIGHT = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]    row_length;
        logic [LEN_W-1:0]    row_count;
        logic [WEIGHT_W-1:0] sample_weight;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0] column_index;
        logic [IDX_W-1:0] row_index;
        logic             frame_last;
    } t_tag;

    localparam t_cfg CFG_RESET = '{
        row_length:    11'd1024,
        row_count:     11'd1024,
        sample_weight: 16'd1
    };

endpackage

// ===== sv/summed_area_table_unit.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// in       | i_valid / o_stall   | i_sample_value
// out      | o_valid / i_stall   | o_area_sum, o_column_index, o_row_index,
//          |                     | o_frame_last
// cfg      | i_cfg_wr_en         | i_cfg_index, i_cfg_data
//
// One transaction per clock sustained while o_stall is low; sums are queued for o_valid.
// The line store takes one read at accept and one write at the sum stage each cycle.
// A four-entry result queue absorbs output stalls; o_stall rises when queue plus
// in-flight transactions fill it.
// Synchronous active-low reset clears position, pipeline and queue; the line store
// is not cleared.
module summed_area_table_unit
    import sat_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
    parameter int SUM_WIDTH      = SUM_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SUM_WIDTH-1:0] o_area_sum,
    output logic [IDX_W-1:0]           o_column_index,
    output logic [IDX_W-1:0]           o_row_index,
    output logic                       o_frame_last
);

    t_cfg                 cfg;
    logic                 accept;
    logic [1:0]           inflight;
    logic                 res_valid;
    logic [SUM_WIDTH-1:0] res_sum;
    t_tag                 res_tag;
    logic [SUM_WIDTH-1:0] out_sum;
    t_tag                 out_tag;
    logic [OUT_CNT_W-1:0] out_count;

    sat_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_stall = (out_count + OUT_CNT_W'(inflight)) >= OUT_CNT_W'(OUT_DEPTH);
    assign accept  = i_valid && !o_stall;

    sat_core #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
        .SUM_WIDTH      (SUM_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_sample_value (i_sample_value),
        .o_inflight     (inflight),
        .o_res_valid    (res_valid),
        .o_res_sum      (res_sum),
        .o_res_tag      (res_tag)
    );

    sat_ofifo #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_sum   (res_sum),
        .i_tag   (res_tag),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_sum   (out_sum),
        .o_tag   (out_tag),
        .o_count (out_count)
    );

    assign o_area_sum     = out_sum;
    assign o_column_index = out_tag.column_index;
    assign o_row_index    = out_tag.row_index;
    assign o_frame_last   = out_tag.frame_last;

endmodule

// ===== sv/sat_ram.sv =====
module sat_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/sat_cfg.sv =====
module sat_cfg
    import sat_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ROW_LENGTH:    n_cfg.row_length    = i_cfg_data[LEN_W-1:0];
                CFG_ROW_COUNT:     n_cfg.row_count     = i_cfg_data[LEN_W-1:0];
                CFG_SAMPLE_WEIGHT: n_cfg.sample_weight = i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/sat_core.sv =====
module sat_core
    import sat_pkg::*;
#(
    parameter int MAX_ROW_LENGTH = MAX_ROW_LENGTH_DEF,
    parameter int SUM_WIDTH      = SUM_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_accept,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic [1:0]                 o_inflight,
    output logic                       o_res_valid,
    output logic [SUM_WIDTH-1:0]       o_res_sum,
    output t_tag                       o_res_tag
);

    localparam int CNT_W = $clog2(MAX_ROW_LENGTH);
    localparam int CMP_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;
    localparam int TERM_W = (SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W;
    localparam int EXT_W = TERM_W + 2;
    localparam logic signed [EXT_W-1:0] SMAX =
        (EXT_W'(1) << (SUM_WIDTH - 1)) - EXT_W'(1);
    localparam logic signed [EXT_W-1:0] SMIN = -SMAX - EXT_W'(1);

    logic [CNT_W-1:0] r_col;
    logic [IDX_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [IDX_W-1:0] n_row;

    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_eff;
    logic [LEN_W-1:0] rows_eff;
    logic             row_end;
    logic             frame_end;
    logic             hit_a;
    logic             hit_b;

    logic                       r_a_valid;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic [CNT_W-1:0]           r_a_col;
    t_tag                       r_a_tag;
    logic                       r_a_first_row;
    logic                       r_a_first_col;
    logic                       r_a_fwd_mid;
    logic                       r_a_fwd_last;

    logic                       r_b_valid;
    logic signed [PROD_W-1:0]   r_b_prod;
    logic [SUM_WIDTH-1:0]       r_b_above;
    logic [CNT_W-1:0]           r_b_col;
    t_tag                       r_b_tag;
    logic                       r_b_first_row;
    logic                       r_b_first_col;
    logic                       r_b_fwd_last;

    logic [SUM_WIDTH-1:0]       r_left;
    logic [SUM_WIDTH-1:0]       r_diag;

    logic signed [PROD_W-1:0]    n_prod;
    logic [SUM_WIDTH-1:0]        ram_rd_data;
    logic signed [SUM_WIDTH-1:0] above_v;
    logic signed [SUM_WIDTH-1:0] left_v;
    logic signed [SUM_WIDTH-1:0] diag_v;
    logic signed [EXT_W-1:0]     sum_ext;
    logic [SUM_WIDTH-1:0]        sat_v;

    assign len_ext = CMP_W'(i_cfg.row_length);

    always_comb begin
        if (len_ext == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_ROW_LENGTH)) begin
            len_eff = CMP_W'(MAX_ROW_LENGTH);
        end else begin
            len_eff = len_ext;
        end

        if (i_cfg.row_count == '0) begin
            rows_eff = LEN_W'(1);
        end else if (i_cfg.row_count > LEN_W'(ROW_LIMIT)) begin
            rows_eff = LEN_W'(ROW_LIMIT);
        end else begin
            rows_eff = i_cfg.row_count;
        end
    end

    assign row_end   = (CMP_W'(r_col) + CMP_W'(1)) >= len_eff;
    assign frame_end = row_end && ((LEN_W'(r_row) + LEN_W'(1)) >= rows_eff);
    assign hit_a     = r_a_valid && (r_a_col == r_col);
    assign hit_b     = r_b_valid && (r_b_col == r_col);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            priority if (frame_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + IDX_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_left    <= '0;
            r_diag    <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
            if (r_b_valid) begin
                r_left <= sat_v;
                r_diag <= above_v;
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_a_sample            <= i_sample_value;
            r_a_col               <= r_col;
            r_a_tag.column_index  <= IDX_W'(r_col);
            r_a_tag.row_index     <= r_row;
            r_a_tag.frame_last    <= frame_end;
            r_a_first_row         <= (r_row == '0);
            r_a_first_col         <= (r_col == '0);
            r_a_fwd_mid           <= hit_b;
            r_a_fwd_last          <= hit_a;
        end
    end

    assign n_prod = PROD_W'(r_a_sample) * PROD_W'(signed'({1'b0, i_cfg.sample_weight}));

    // product and line store stage
    always_ff @(posedge i_clk) begin
        r_b_prod      <= n_prod;
        r_b_above     <= r_a_fwd_mid ? r_left : ram_rd_data;
        r_b_col       <= r_a_col;
        r_b_tag       <= r_a_tag;
        r_b_first_row <= r_a_first_row;
        r_b_first_col <= r_a_first_col;
        r_b_fwd_last  <= r_a_fwd_last;
    end

    always_comb begin
        if (r_b_first_row) begin
            above_v = '0;
        end else if (r_b_fwd_last) begin
            above_v = r_left;
        end else begin
            above_v = r_b_above;
        end
        left_v  = r_b_first_col ? '0 : r_left;
        diag_v  = (r_b_first_row || r_b_first_col) ? '0 : r_diag;
        sum_ext = EXT_W'(r_b_prod) + EXT_W'(left_v) + EXT_W'(above_v) - EXT_W'(diag_v);
        if (sum_ext > SMAX) begin
            sat_v = SMAX[SUM_WIDTH-1:0];
        end else if (sum_ext < SMIN) begin
            sat_v = SMIN[SUM_WIDTH-1:0];
        end else begin
            sat_v = sum_ext[SUM_WIDTH-1:0];
        end
    end

    sat_ram #(
        .WIDTH (SUM_WIDTH),
        .DEPTH (MAX_ROW_LENGTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (r_b_valid),
        .i_wr_addr (r_b_col),
        .i_wr_data (sat_v),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd_data)
    );

    assign o_inflight  = {1'b0, r_a_valid} + {1'b0, r_b_valid};
    assign o_res_valid = r_b_valid;
    assign o_res_sum   = sat_v;
    assign o_res_tag   = r_b_tag;

`ifndef SYNTHESIS
    a_fwd_last_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_fwd_last |-> $past(r_b_valid))
        else $error("forward from last result without a producing transaction");

    a_fwd_mid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_fwd_mid |-> $past(r_b_valid))
        else $error("forward from earlier result without a producing transaction");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && frame_end |=> (r_col == '0) && (r_row == '0))
        else $error("position did not restart after frame end");
`endif

endmodule

// ===== sv/sat_ofifo.sv =====
module sat_ofifo
    import sat_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [SUM_WIDTH-1:0] i_sum,
    input  t_tag                 i_tag,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [SUM_WIDTH-1:0] o_sum,
    output t_tag                 o_tag,
    output logic [OUT_CNT_W-1:0] o_count
);

    logic [SUM_WIDTH-1:0] r_sum [OUT_DEPTH];
    t_tag                 r_tag [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 take;

    assign o_valid = (r_count != '0);
    assign take    = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_sum[r_wr_ptr] <= i_sum;
            r_tag[r_wr_ptr] <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_W'(1);
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_W'(1);
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(take);
        end
    end

    assign o_sum   = r_sum[r_rd_ptr];
    assign o_tag   = r_tag[r_rd_ptr];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !take |-> r_count < OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");
`endif

endmodule
